/* hw/rtl/svp_pkg.sv */
// Shared types, codes and constants of the service spec parser.
package svp_pkg;

    localparam int unsigned DEFAULT_MAX_SPECS = 8;

    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [16:0] PORT_LIMIT = 17'd65535;
    localparam logic [16:0] PORT_OVER = 17'd65536;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    localparam logic [7:0] MIN_HOST_RESET = 8'd5;
    localparam logic [7:0] MIN_SERVICE_RESET = 8'd2;

    typedef enum logic [0:0] {
        REG_MIN_HOST = 1'b0,
        REG_MIN_SERVICE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        FLD_HOST = 2'd0,
        FLD_PORT = 2'd1,
        FLD_SERVICE = 2'd2
    } field_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_DELIM = 3'd1,
        ST_BAD_PORT = 3'd2,
        ST_BAD_HOST = 3'd3,
        ST_BAD_SERVICE = 3'd4
    } status_t;

    typedef struct packed {
        logic final_result;
        logic [2:0] record_index;
        logic [7:0] service_length;
        logic [7:0] host_length;
        logic [15:0] port_number;
        status_t status;
    } result_t;

endpackage

/* hw/rtl/service_spec_parser.sv */
// Top level of the service spec parser: byte parser, result buffer and APB registers.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata[7:0] data_byte, tlast end_of_payload
//  m_axis    out        tdata: status, port_number, host_length, service_length,
//                       record_index; tlast final_result
//  apb       in/out     min_host_length at 0x0, min_service_length at 0x4
//
// Every byte beat is parsed in the cycle it is accepted, so one beat is taken per clock while s_tready is high.
// A result is registered in the output buffer when the byte that closes its record is accepted.
// A two-entry output buffer lets input continue while one result waits; input stalls
// only when both entries are full. Reset is synchronous and restores the register defaults.
module service_spec_parser #(
    parameter int unsigned MAX_SPECS = svp_pkg::DEFAULT_MAX_SPECS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // [7:0] data_byte
    input  logic [svp_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tlast,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [2:0] status, [18:3] port_number, [26:19] host_length,
    // [34:27] service_length, [37:35] record_index, [39:38] zero
    output logic [svp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [svp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [svp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [svp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import svp_pkg::*;

    logic [7:0] min_host_reg;
    logic [7:0] min_service_reg;

    field_t field_reg, field_next;
    logic [16:0] port_acc_reg, port_acc_next;
    logic digits_ended_reg, digits_ended_next;
    logic [7:0] host_count_reg, host_count_next;
    logic [7:0] service_count_reg, service_count_next;
    logic [3:0] records_done_reg, records_done_next;
    logic stopped_reg, stopped_next;

    result_t out_data_reg, skid_data_reg, res;
    logic out_valid_reg, skid_valid_reg;
    logic res_valid;

    logic s_accept, m_take, apb_write;
    logic [7:0] c;
    logic is_digit;
    logic [19:0] acc_sum;
    logic is_last_rec;
    status_t rec_status;
    logic [15:0] port_sat;

    assign pready = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign prdata = (reg_index_t'(paddr[2]) == REG_MIN_SERVICE) ?
                    {24'd0, min_service_reg} : {24'd0, min_host_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_host_reg <= MIN_HOST_RESET;
            min_service_reg <= MIN_SERVICE_RESET;
        end else if (apb_write) begin
            case (reg_index_t'(paddr[2]))
                REG_MIN_HOST: min_host_reg <= pwdata[7:0];
                REG_MIN_SERVICE: min_service_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_take = m_tvalid && m_tready;

    assign c = s_tdata[7:0];
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign acc_sum = {port_acc_reg, 3'b000} + {2'b00, port_acc_reg, 1'b0}
                     + {16'd0, c[3:0]};
    assign is_last_rec = ({1'b0, records_done_reg} + 5'd1) >= 5'(MAX_SPECS);
    assign port_sat = (port_acc_reg > PORT_LIMIT) ? PORT_LIMIT[15:0] : port_acc_reg[15:0];

    always_comb begin
        if (port_acc_reg == 17'd0 || port_acc_reg > PORT_LIMIT) begin
            rec_status = ST_BAD_PORT;
        end else if (host_count_reg < min_host_reg) begin
            rec_status = ST_BAD_HOST;
        end else if (service_count_reg < min_service_reg) begin
            rec_status = ST_BAD_SERVICE;
        end else begin
            rec_status = ST_OK;
        end
    end

    always_comb begin
        field_next = field_reg;
        port_acc_next = port_acc_reg;
        digits_ended_next = digits_ended_reg;
        host_count_next = host_count_reg;
        service_count_next = service_count_reg;
        records_done_next = records_done_reg;
        stopped_next = stopped_reg;
        res_valid = 1'b0;
        res = '{final_result: 1'b1, record_index: records_done_reg[2:0],
                service_length: 8'd0, host_length: 8'd0, port_number: 16'd0,
                status: ST_BAD_DELIM};
        if (!stopped_reg) begin
            case (field_reg)
                FLD_HOST: begin
                    if (c == CHAR_COLON) begin
                        field_next = FLD_PORT;
                    end else if (host_count_reg < COUNT_MAX) begin
                        host_count_next = host_count_reg + 8'd1;
                    end
                end
                FLD_PORT: begin
                    if (c == CHAR_COLON) begin
                        field_next = FLD_SERVICE;
                    end else if (is_digit && !digits_ended_reg) begin
                        port_acc_next = (acc_sum > {3'b000, PORT_LIMIT}) ?
                                        PORT_OVER : acc_sum[16:0];
                    end else begin
                        digits_ended_next = 1'b1;
                    end
                end
                default: begin
                    if (c == CHAR_COMMA) begin
                        res_valid = 1'b1;
                        if (rec_status == ST_OK && s_tlast && !is_last_rec) begin
                            res.record_index = 3'(records_done_reg + 4'd1);
                        end else begin
                            res = '{final_result: (rec_status != ST_OK) || is_last_rec,
                                    record_index: records_done_reg[2:0],
                                    service_length: service_count_reg,
                                    host_length: host_count_reg,
                                    port_number: port_sat,
                                    status: rec_status};
                        end
                        records_done_next = records_done_reg + 4'd1;
                        field_next = FLD_HOST;
                        port_acc_next = 17'd0;
                        digits_ended_next = 1'b0;
                        host_count_next = 8'd0;
                        service_count_next = 8'd0;
                        if (rec_status != ST_OK || is_last_rec) begin
                            stopped_next = 1'b1;
                        end
                    end else if (service_count_reg < COUNT_MAX) begin
                        service_count_next = service_count_reg + 8'd1;
                    end
                end
            endcase
            if (s_tlast) begin
                res_valid = 1'b1;
            end
        end
        if (s_tlast) begin
            field_next = FLD_HOST;
            port_acc_next = 17'd0;
            digits_ended_next = 1'b0;
            host_count_next = 8'd0;
            service_count_next = 8'd0;
            records_done_next = 4'd0;
            stopped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= FLD_HOST;
            port_acc_reg <= 17'd0;
            digits_ended_reg <= 1'b0;
            host_count_reg <= 8'd0;
            service_count_reg <= 8'd0;
            records_done_reg <= 4'd0;
            stopped_reg <= 1'b0;
        end else if (s_accept) begin
            field_reg <= field_next;
            port_acc_reg <= port_acc_next;
            digits_ended_reg <= digits_ended_next;
            host_count_reg <= host_count_next;
            service_count_reg <= service_count_next;
            records_done_reg <= records_done_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_accept && res_valid) begin
            if (!out_valid_reg || m_take) begin
                out_valid_reg <= 1'b1;
                out_data_reg <= res;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg <= res;
            end
        end else if (m_take) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast = out_data_reg.final_result;
    assign m_tdata = {2'b00, out_data_reg.record_index, out_data_reg.service_length,
                      out_data_reg.host_length, out_data_reg.port_number,
                      out_data_reg.status};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry is full while the output entry is empty.");

    a_records_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        records_done_reg <= 5'(MAX_SPECS))
        else $error("Record count exceeded the record limit.");

    a_payload_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> records_done_reg == 4'd0 && !stopped_reg &&
        field_reg == FLD_HOST && host_count_reg == 8'd0)
        else $error("Parser state not cleared after the last beat of a payload.");

    a_error_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_data_reg.status != ST_OK |-> m_tlast)
        else $error("Error result without the final flag.");

    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && stopped_reg && !out_valid_reg |=> !out_valid_reg)
        else $error("Result produced while the parser is stopped.");

endmodule
